// ----- hdl/vnls_pkg.sv -----
// ----------------------------------------------------------------------------
// vnls_pkg
// Shared constants and the queue item type of the value-noise lattice sampler.
// ----------------------------------------------------------------------------
package vnls_pkg;

  // lattice geometry
  localparam int LATTICE_COLS = 64;
  localparam int LATTICE_ROWS = 64;
  localparam int COL_W        = $clog2(LATTICE_COLS);
  localparam int ROW_W        = $clog2(LATTICE_ROWS);

  // field widths
  localparam int IN_COL_W = 6;
  localparam int IN_ROW_W = 6;
  localparam int VAL_W    = 16;
  localparam int PIX_W    = 12;
  localparam int SPC_W    = 9;
  localparam int FRAC_W   = 16;

  // request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one classified item: a load carries column, row and value, a sample carries
  // cell index i, j and the two fractions; flag is drop for a load and out of
  // range for a sample
  typedef struct packed {
    logic               kind;
    logic               flag;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [VAL_W-1:0]   val;
    logic [FRAC_W-1:0]  fy;
  } item_t;

endpackage

// ----- hdl/value_noise_lattice_sampler.sv -----
// ----------------------------------------------------------------------------
// value_noise_lattice_sampler
// Value-noise sampler over a 64 x 64 lattice with smoothstep fade and bilinear
// blend; a load beat writes one lattice entry, a sample beat returns moisture.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while busy is low: loads and samples
// may be mixed freely and are handled strictly in order, so a sample sees
// every load accepted before it. A sample's result appears on moisture and
// out_of_range with done high for one cycle after its beat passes the
// pipelined divider (one quotient bit per stage for i and the 16-bit fraction),
// the front-to-back queue and the back's register stages (registered bank
// read, two fade multiplies, blend along x), whose fourth register stage
// registers the blend along y. Loads give
// no result. Results cannot be held off, so the back never
// stalls and busy stays low in use. The lattice has no reset and needs no
// clearing pass; sampling a cell whose four corners were not all loaded gives
// an undefined moisture value. lattice_spacing may be written through the cfg
// channel only while no beat is in flight; zero acts as one.
module value_noise_lattice_sampler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type,
  input  logic [vnls_pkg::IN_COL_W-1:0] lattice_col,
  input  logic [vnls_pkg::IN_ROW_W-1:0] lattice_row,
  input  logic [vnls_pkg::VAL_W-1:0]    lattice_value,
  input  logic [vnls_pkg::PIX_W-1:0]    pixel_x,
  input  logic [vnls_pkg::PIX_W-1:0]    pixel_y,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vnls_pkg::SPC_W-1:0]    cfg_data,
  output logic                          done,
  output logic [vnls_pkg::VAL_W-1:0]    moisture,
  output logic                          out_of_range
);
  import vnls_pkg::*;

  logic [SPC_W-1:0] lattice_spacing;
  logic [SPC_W-1:0] spacing_eff;
  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  logic             q_full;
  item_t            f_item;
  item_t            q_head;

  assign cfg_ready   = 1'b1;
  assign spacing_eff = (lattice_spacing == '0) ? SPC_W'(1) : lattice_spacing;

  always_ff @(posedge clk) begin
    if (rst) begin
      lattice_spacing <= SPC_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      lattice_spacing <= cfg_data;
    end
  end

  vnls_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .lattice_col   (lattice_col),
    .lattice_row   (lattice_row),
    .lattice_value (lattice_value),
    .pixel_x       (pixel_x),
    .pixel_y       (pixel_y),
    .spacing       (spacing_eff),
    .q_full        (q_full),
    .push          (q_push),
    .item          (f_item)
  );

  // the back takes the head beat every cycle
  assign q_pop = q_valid;

  vnls_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (f_item),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head),
    .full      (q_full)
  );

  vnls_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_valid),
    .in_item      (q_head),
    .done         (done),
    .moisture     (moisture),
    .out_of_range (out_of_range)
  );

`ifndef SYNTH
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    done && out_of_range |-> moisture == '0)
    else $error("out of range result with nonzero moisture");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push && q_full |-> q_pop)
    else $error("push into full queue");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done && !busy)
    else $error("activity right after reset");
`endif

endmodule

// ----- hdl/vnls_queue.sv -----
// ----------------------------------------------------------------------------
// vnls_queue
// Small register FIFO that decouples the divider front from the lattice back.
// ----------------------------------------------------------------------------
module vnls_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  vnls_pkg::item_t push_item,
  input  logic           pop,
  output logic           valid,
  output vnls_pkg::item_t head,
  output logic           full
);
  import vnls_pkg::*;

  item_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign valid   = (count != '0);
  assign full    = (count == QCNT_W'(QDEPTH));
  assign head    = entries[rd_ptr];
  assign do_push = push && (!full || pop);
  assign do_pop  = pop && valid;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (do_push && !do_pop)      count <= QCNT_W'(count + 1'b1);
      else if (do_pop && !do_push) count <= QCNT_W'(count - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_item;
  end

endmodule

// ----- hdl/vnls_front.sv -----
// ----------------------------------------------------------------------------
// vnls_front
// Accepts items, runs both pixel coordinates through a pipelined restoring
// divider (one quotient bit per stage) and classifies the result.
// ----------------------------------------------------------------------------
module vnls_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type,
  input  logic [vnls_pkg::IN_COL_W-1:0] lattice_col,
  input  logic [vnls_pkg::IN_ROW_W-1:0] lattice_row,
  input  logic [vnls_pkg::VAL_W-1:0]    lattice_value,
  input  logic [vnls_pkg::PIX_W-1:0]    pixel_x,
  input  logic [vnls_pkg::PIX_W-1:0]    pixel_y,
  input  logic [vnls_pkg::SPC_W-1:0]    spacing,
  input  logic                          q_full,
  output logic                          push,
  output vnls_pkg::item_t               item
);
  import vnls_pkg::*;

  // dividend is the coordinate scaled by 2^16: upper quotient bits give the
  // cell index, lower ones the fraction
  localparam int DIV_W = PIX_W + FRAC_W;
  localparam int NSTG  = DIV_W;

  typedef struct packed {
    logic                kind;
    logic [SPC_W-1:0]    ax;
    logic [DIV_W-1:0]    qx;
    logic [SPC_W-1:0]    ay;
    logic [DIV_W-1:0]    qy;
    logic [IN_COL_W-1:0] col;
    logic [IN_ROW_W-1:0] row;
    logic [VAL_W-1:0]    val;
  } dstage_t;

  function automatic logic [SPC_W+DIV_W-1:0] div_step(input logic [SPC_W-1:0] a,
                                                      input logic [DIV_W-1:0] q,
                                                      input logic [SPC_W-1:0] d);
    logic [SPC_W:0]   t;
    logic [SPC_W-1:0] a_n;
    logic             q_bit;
    t = {a, q[DIV_W-1]};
    if (t >= {1'b0, d}) begin
      a_n   = SPC_W'(t - {1'b0, d});
      q_bit = 1'b1;
    end else begin
      a_n   = t[SPC_W-1:0];
      q_bit = 1'b0;
    end
    return {a_n, q[DIV_W-2:0], q_bit};
  endfunction

  function automatic dstage_t advance(input dstage_t s, input logic [SPC_W-1:0] d);
    dstage_t r;
    r = s;
    {r.ax, r.qx} = div_step(s.ax, s.qx, d);
    {r.ay, r.qy} = div_step(s.ay, s.qy, d);
    return r;
  endfunction

  dstage_t             stg [NSTG];
  dstage_t             entry;
  logic [NSTG-1:0]     vld;
  logic                stall;
  logic                accept;
  dstage_t             last;
  logic [PIX_W-1:0]    ci;
  logic [PIX_W-1:0]    cj;

  assign stall  = vld[NSTG-1] && q_full;
  assign busy   = stall;
  assign accept = start && !busy;

  always_comb begin
    entry.kind = req_type;
    entry.ax   = '0;
    entry.qx   = {pixel_x, FRAC_W'(0)};
    entry.ay   = '0;
    entry.qy   = {pixel_y, FRAC_W'(0)};
    entry.col  = lattice_col;
    entry.row  = lattice_row;
    entry.val  = lattice_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (!stall) begin
      vld <= {vld[NSTG-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) stg[0] <= advance(entry, spacing);
  end

  for (genvar k = 1; k < NSTG; k++) begin : g_stg
    always_ff @(posedge clk) begin
      if (!stall) stg[k] <= advance(stg[k-1], spacing);
    end
  end

  // classify the item leaving the divider
  assign last = stg[NSTG-1];
  assign ci   = last.qx[DIV_W-1:FRAC_W];
  assign cj   = last.qy[DIV_W-1:FRAC_W];
  assign push = vld[NSTG-1] && !q_full;

  always_comb begin
    item.kind = last.kind;
    if (last.kind == REQ_LOAD) begin
      item.flag = (32'(last.col) >= LATTICE_COLS) || (32'(last.row) >= LATTICE_ROWS);
      item.col  = COL_W'(last.col);
      item.row  = ROW_W'(last.row);
      item.val  = last.val;
      item.fy   = '0;
    end else begin
      item.flag = (32'(ci) + 1 >= LATTICE_COLS) || (32'(cj) + 1 >= LATTICE_ROWS);
      item.col  = COL_W'(ci);
      item.row  = ROW_W'(cj);
      item.val  = last.qx[FRAC_W-1:0];
      item.fy   = last.qy[FRAC_W-1:0];
    end
  end

endmodule

// ----- hdl/vnls_back.sv -----
// ----------------------------------------------------------------------------
// vnls_back
// Four-bank lattice store (row and column parity), smoothstep fade and the
// bilinear blend, four register stages from queue head to result.
// ----------------------------------------------------------------------------
module vnls_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  vnls_pkg::item_t            in_item,
  output logic                       done,
  output logic [vnls_pkg::VAL_W-1:0] moisture,
  output logic                       out_of_range
);
  import vnls_pkg::*;

  localparam int    NBANK      = 4;
  localparam int    BANK_AW    = (ROW_W - 1) + (COL_W - 1);
  localparam int    BANK_DEPTH = 1 << BANK_AW;
  localparam int    K_W        = VAL_W + 2;
  localparam logic [K_W-1:0] FADE_K3 = K_W'(3 * 65536);

  function automatic logic [VAL_W-1:0] mix(input logic [VAL_W-1:0] a,
                                           input logic [VAL_W-1:0] b,
                                           input logic [VAL_W-1:0] w);
    logic signed [VAL_W:0]     diff;
    logic signed [2*VAL_W+1:0] prod;
    logic signed [2*VAL_W+1:0] acc;
    // a*(1-w) + b*w rewritten as a + (b-a)*w
    diff = signed'({1'b0, b}) - signed'({1'b0, a});
    prod = diff * signed'({1'b0, w});
    acc  = signed'({2'b00, a, VAL_W'(0)}) + prod;
    return acc[2*VAL_W-1:VAL_W];
  endfunction

  logic                 is_sample;
  logic                 i_n;
  logic                 j_n;
  logic [COL_W-1:0]     col_p1;
  logic [ROW_W-1:0]     row_p1;
  logic [BANK_AW-1:0]   waddr;
  logic [BANK_AW-1:0]   raddr [NBANK];
  logic [NBANK-1:0]     we;
  logic [VAL_W-1:0]     rd    [NBANK];

  assign is_sample = in_valid && (in_item.kind == REQ_SAMPLE);
  assign i_n       = in_item.col[0];
  assign j_n       = in_item.row[0];
  assign col_p1    = COL_W'(in_item.col + 1'b1);
  assign row_p1    = ROW_W'(in_item.row + 1'b1);
  assign waddr     = {in_item.row[ROW_W-1:1], in_item.col[COL_W-1:1]};

  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    logic [VAL_W-1:0] mem [BANK_DEPTH];
    logic [COL_W-1:0] c_sel;
    logic [ROW_W-1:0] r_sel;

    // each bank holds exactly one of the four neighbors
    assign c_sel    = (i_n == b[0]) ? in_item.col : col_p1;
    assign r_sel    = (j_n == b[1]) ? in_item.row : row_p1;
    assign raddr[b] = {r_sel[ROW_W-1:1], c_sel[COL_W-1:1]};
    assign we[b]    = in_valid && (in_item.kind == REQ_LOAD) && !in_item.flag &&
                      ({j_n, i_n} == 2'(b));

    always_ff @(posedge clk) begin
      if (we[b]) mem[waddr] <= in_item.val;
      rd[b] <= mem[raddr[b]];
    end
  end

  // stage 1: bank read, fade squares
  logic              v1, oor1, i1, j1;
  logic [VAL_W-1:0]  t2x1, t2y1;
  logic [K_W-1:0]    kx1, ky1;
  logic [2*VAL_W-1:0] sqx, sqy;

  assign sqx = in_item.val * in_item.val;
  assign sqy = in_item.fy * in_item.fy;

  always_ff @(posedge clk) begin
    oor1 <= in_item.flag;
    i1   <= i_n;
    j1   <= j_n;
    t2x1 <= sqx[2*VAL_W-1:VAL_W];
    t2y1 <= sqy[2*VAL_W-1:VAL_W];
    kx1  <= FADE_K3 - K_W'({in_item.val, 1'b0});
    ky1  <= FADE_K3 - K_W'({in_item.fy, 1'b0});
  end

  // stage 2: fade product, neighbor reorder
  logic              v2, oor2;
  logic [VAL_W-1:0]  sx2, sy2, a2, b2, c2, d2;
  logic [VAL_W+K_W-1:0] px, py;
  logic [VAL_W-1:0]  r0_lo, r0_hi, r1_lo, r1_hi;

  assign px    = t2x1 * kx1;
  assign py    = t2y1 * ky1;
  assign r0_lo = i1 ? rd[1] : rd[0];
  assign r0_hi = i1 ? rd[0] : rd[1];
  assign r1_lo = i1 ? rd[3] : rd[2];
  assign r1_hi = i1 ? rd[2] : rd[3];

  always_ff @(posedge clk) begin
    oor2 <= oor1;
    sx2  <= (px[VAL_W+K_W-1:2*VAL_W] != '0) ? '1 : px[2*VAL_W-1:VAL_W];
    sy2  <= (py[VAL_W+K_W-1:2*VAL_W] != '0) ? '1 : py[2*VAL_W-1:VAL_W];
    a2   <= j1 ? r1_lo : r0_lo;
    b2   <= j1 ? r1_hi : r0_hi;
    c2   <= j1 ? r0_lo : r1_lo;
    d2   <= j1 ? r0_hi : r1_hi;
  end

  // stage 3: blend along x
  logic              v3, oor3;
  logic [VAL_W-1:0]  top3, bot3, sy3;

  always_ff @(posedge clk) begin
    oor3 <= oor2;
    top3 <= mix(a2, b2, sx2);
    bot3 <= mix(c2, d2, sx2);
    sy3  <= sy2;
  end

  // stage 4: blend along y
  always_ff @(posedge clk) begin
    moisture     <= oor3 ? '0 : mix(top3, bot3, sy3);
    out_of_range <= oor3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= is_sample;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

endmodule
